### rtl/core/rsc_pkg.sv
// rsc_pkg: shared types, sizes and codes of the RPN stack calculator.
// No dependencies; imported by every module under rtl/core.
package rsc_pkg;

   // Sizes
   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int OPCODE_W    = 3;
   localparam int STATUS_W    = 2;
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   localparam logic [DEPTH_W-1:0] FULL_DEPTH = DEPTH_W'(STACK_DEPTH);

   // Saturation limits of the signed value range
   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   // Opcodes; the two unused codes behave as no-op
   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_NOP    = 3'd4,
      OP_FINISH = 3'd5
   } op_type;

   // Status reported with each result beat
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_LEFTOVER = 2'd2,
      ST_FAILED   = 2'd3
   } status_type;

   // One stack entry; an invalid entry always carries value zero
   typedef struct packed {
      logic                   invalid;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

   localparam entry_type INVALID_ENTRY = '{invalid: 1'b1, value: '0};

endpackage

### rtl/core/rsc_spill_ram.sv
// rsc_spill_ram: storage for stack entries below the two held in registers.
// One write port, one registered read port with write-to-read bypass. Uses rsc_pkg.
module rsc_spill_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [rsc_pkg::ADDR_W-1:0] wr_addr,
   input  rsc_pkg::entry_type         wr_data,
   input  logic [rsc_pkg::ADDR_W-1:0] rd_addr,
   output rsc_pkg::entry_type         rd_data
);
   import rsc_pkg::*;

   entry_type mem_ff [STACK_DEPTH];
   entry_type rd_data_ff;

   // Write, and read with bypass so a spill is visible the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rsc_alu.sv
// rsc_alu: saturating add, subtract and Q16.16 multiply of two stack entries.
// Invalid operands give an invalid zero result. Uses rsc_pkg.
module rsc_alu (
   input  rsc_pkg::op_type    op,
   input  rsc_pkg::entry_type lhs,
   input  rsc_pkg::entry_type rhs,
   output rsc_pkg::entry_type res
);
   import rsc_pkg::*;

   localparam int W = VALUE_WIDTH;
   localparam logic [2*W-1:0] ROUND_HALF = (2*W)'(1) << (FRAC_BITS - 1);
   localparam logic [2*W-1:0] POS_LIMIT  = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [2*W-1:0] NEG_LIMIT  = POS_LIMIT + (2*W)'(1);

   logic [W:0]     sum_ext;
   logic [W:0]     diff_ext;
   logic [W-1:0]   add_val;
   logic [W-1:0]   sub_val;
   logic [W-1:0]   mag_l;
   logic [W-1:0]   mag_r;
   logic           mul_neg;
   logic [2*W-1:0] prod;
   logic [2*W-1:0] prod_rnd;
   logic [2*W-1:0] quot;
   logic [W-1:0]   mul_val;
   logic [W-1:0]   op_val;

   // Add / subtract with one guard bit, clip on overflow
   assign sum_ext  = {lhs.value[W-1], lhs.value} + {rhs.value[W-1], rhs.value};
   assign diff_ext = {lhs.value[W-1], lhs.value} - {rhs.value[W-1], rhs.value};

   always_comb begin
      if (sum_ext[W] != sum_ext[W-1]) begin
         add_val = sum_ext[W] ? VALUE_MIN : VALUE_MAX;
      end else begin
         add_val = sum_ext[W-1:0];
      end
      if (diff_ext[W] != diff_ext[W-1]) begin
         sub_val = diff_ext[W] ? VALUE_MIN : VALUE_MAX;
      end else begin
         sub_val = diff_ext[W-1:0];
      end
   end

   // Multiply magnitudes, round half away from zero, then clip and re-sign
   assign mag_l    = lhs.value[W-1] ? ({W{1'b0}} - lhs.value) : lhs.value;
   assign mag_r    = rhs.value[W-1] ? ({W{1'b0}} - rhs.value) : rhs.value;
   assign mul_neg  = lhs.value[W-1] ^ rhs.value[W-1];
   assign prod     = mag_l * mag_r;
   assign prod_rnd = prod + ROUND_HALF;
   assign quot     = prod_rnd >> FRAC_BITS;

   always_comb begin
      if (mul_neg) begin
         mul_val = (quot > NEG_LIMIT) ? VALUE_MIN : ({W{1'b0}} - quot[W-1:0]);
      end else begin
         mul_val = (quot > POS_LIMIT) ? VALUE_MAX : quot[W-1:0];
      end
   end

   // Operation select
   always_comb begin
      case (op)
         OP_SUB:  op_val = sub_val;
         OP_MUL:  op_val = mul_val;
         default: op_val = add_val;
      endcase
      res.invalid = lhs.invalid | rhs.invalid;
      res.value   = res.invalid ? {W{1'b0}} : op_val;
   end

endmodule

### rtl/core/rpn_stack_calculator_top.sv
// rpn_stack_calculator_top: reverse Polish calculator over a 16-entry stack.
// Depends on rsc_pkg, rsc_alu and rsc_spill_ram.
//
// Usage:
//   req_* carries one token per beat: opcode and a signed Q16.16 operand.
//   rsp_* returns exactly one beat per token: top value (or popped result
//   on finish), its valid flag, a status code and the stack depth after it.
//   Both channels are valid/ready; a beat moves when valid and ready are high.
// Path: a req beat passes the input register, then the result register, to
//   its rsp_valid. Throughput: one token per cycle while rsp_ready is high.
//   The top two entries live in registers; the rest sit in a spill RAM whose
//   single read port prefetches the third entry, so each token needs one
//   pass through the ALU (one 32x32 multiplier) and nothing else.
// Reset: synchronous, active high. Empties the stack and both registers;
//   no clearing pass, the block takes a token on the first cycle after reset.
// Stall: while rsp_ready is low the result beat is held; one more token is
//   taken into the input register, then req_ready drops until rsp drains.
module rpn_stack_calculator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [rsc_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [rsc_pkg::VALUE_WIDTH-1:0] req_operand_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rsc_pkg::VALUE_WIDTH-1:0] rsp_result_value,
   output logic                                rsp_result_valid,
   output logic [rsc_pkg::STATUS_W-1:0]        rsp_status_code,
   output logic [rsc_pkg::DEPTH_W-1:0]         rsp_depth_now
);
   import rsc_pkg::*;

   // Input register
   logic                   in_valid_ff;
   op_type                 in_op_ff;
   logic [VALUE_WIDTH-1:0] in_value_ff;

   // Stack state: top two entries and depth
   entry_type              top_ff,   top_in;
   entry_type              next_ff,  next_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_flag_ff,  rsp_flag_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [DEPTH_W-1:0]     rsp_depth_ff;

   logic                   advance;
   logic                   have_top;
   logic                   have_next;
   entry_type              rhs;
   entry_type              lhs;
   entry_type              alu_res;
   entry_type              third;
   entry_type              fin_ent;
   logic                   is_finish;
   logic                   wr_en;
   logic [DEPTH_W-1:0]     wr_pos;
   logic [DEPTH_W-1:0]     rd_pos;

   // Handshake: input stage moves on when the result register is free
   assign advance   = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // Operands; missing ones read as invalid
   assign have_top  = (depth_ff != '0);
   assign have_next = (depth_ff > DEPTH_W'(1));
   assign rhs       = have_top  ? top_ff  : INVALID_ENTRY;
   assign lhs       = have_next ? next_ff : INVALID_ENTRY;

   rsc_alu u_alu (
      .op  (in_op_ff),
      .lhs (lhs),
      .rhs (rhs),
      .res (alu_res)
   );

   // Spill RAM: entry at stack position i sits at address i
   assign wr_pos = depth_ff - DEPTH_W'(2);
   assign rd_pos = (advance ? depth_in : depth_ff) - DEPTH_W'(3);

   rsc_spill_ram u_spill (
      .clock   (clock),
      .wr_en   (wr_en & advance),
      .wr_addr (wr_pos[ADDR_W-1:0]),
      .wr_data (next_ff),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (third)
   );

   // Token decode and next stack state
   always_comb begin
      top_in        = top_ff;
      next_in       = next_ff;
      depth_in      = depth_ff;
      wr_en         = 1'b0;
      rsp_status_in = ST_OK;
      is_finish     = 1'b0;
      fin_ent       = rhs;
      unique case (in_op_ff) inside
         OP_PUSH: begin
            if (depth_ff == FULL_DEPTH) begin
               rsp_status_in = ST_FULL;
            end else begin
               top_in   = '{invalid: 1'b0, value: in_value_ff};
               next_in  = top_ff;
               depth_in = depth_ff + DEPTH_W'(1);
               wr_en    = have_next;
            end
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            top_in   = alu_res;
            next_in  = third;
            depth_in = have_next ? (depth_ff - DEPTH_W'(1)) : DEPTH_W'(1);
         end
         OP_FINISH: begin
            is_finish = 1'b1;
            depth_in  = '0;
            if (have_next) begin
               rsp_status_in = ST_LEFTOVER;
            end else if (rhs.invalid) begin
               rsp_status_in = ST_FAILED;
            end
         end
         default: begin
         end
      endcase

      // Reported value: popped result on finish, else the new top, or an invalid zero if the stack is empty
      if (is_finish) begin
         rsp_flag_in  = ~fin_ent.invalid;
         rsp_value_in = fin_ent.invalid ? '0 : fin_ent.value;
      end else if (depth_in != '0) begin
         rsp_flag_in  = ~top_in.invalid;
         rsp_value_in = top_in.invalid ? '0 : top_in.value;
      end else begin
         rsp_flag_in  = 1'b0;
         rsp_value_in = '0;
      end
   end

   // Control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            depth_ff     <= depth_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_ready && req_valid) begin
         in_op_ff    <= op_type'(req_opcode);
         in_value_ff <= req_operand_value;
      end
      if (advance) begin
         top_ff        <= top_in;
         next_ff       <= next_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_flag_ff   <= rsp_flag_in;
         rsp_status_ff <= rsp_status_in;
         rsp_depth_ff  <= depth_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_valid = rsp_flag_ff;
   assign rsp_status_code  = rsp_status_ff;
   assign rsp_depth_now    = rsp_depth_ff;

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= FULL_DEPTH)
      else $error("stack depth beyond capacity");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_PUSH && depth_ff == FULL_DEPTH)
      |=> (depth_ff == $past(depth_ff)) && (rsp_status_code == ST_FULL))
      else $error("push on full stack changed depth");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_FINISH) |=> (depth_ff == '0) && rsp_valid)
      else $error("finish did not empty the stack");

   a_invalid_top_zero: assert property (@(posedge clock) disable iff (reset)
      (depth_ff != '0 && top_ff.invalid) |-> (top_ff.value == '0))
      else $error("invalid top entry holds a nonzero value");

endmodule
